FILE: hw/rtl/drm_pkg.sv
// Package for the dirty rectangle merge list: sizes, codes, rectangle type and helpers.
// No dependencies.
package drm_pkg;
    localparam int MAX_RECTS  = 16;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_RECTS);
    localparam int CNT_W      = $clog2(MAX_RECTS + 1);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] REG_MAX_LEFT   = 2'd0;
    localparam logic [1:0] REG_MAX_TOP    = 2'd1;
    localparam logic [1:0] REG_MAX_RIGHT  = 2'd2;
    localparam logic [1:0] REG_MAX_BOTTOM = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord l;
        t_coord t;
        t_coord r;
        t_coord b;
    } t_rect;

    localparam int RECT_W = $bits(t_rect);

    // memory request from the sequencer
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        t_rect             wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             gave;
        logic             busy;
    } t_stat;

    function automatic t_coord cmax(input t_coord a, input t_coord b);
        cmax = (a > b) ? a : b;
    endfunction

    function automatic t_coord cmin(input t_coord a, input t_coord b);
        cmin = (a < b) ? a : b;
    endfunction

    // positive-area intersection
    function automatic logic rect_overlap(input t_rect p, input t_rect q);
        rect_overlap = (cmax(p.l, q.l) < cmin(p.r, q.r)) &&
                       (cmax(p.t, q.t) < cmin(p.b, q.b));
    endfunction

    function automatic t_rect rect_union(input t_rect p, input t_rect q);
        t_rect u;
        u.l = cmin(p.l, q.l);
        u.t = cmin(p.t, q.t);
        u.r = cmax(p.r, q.r);
        u.b = cmax(p.b, q.b);
        rect_union = u;
    endfunction
endpackage

FILE: hw/rtl/drm_if.sv
// Channel interfaces of the dirty rectangle merge list (request and response).
// Depends on drm_pkg.
interface drm_req_if import drm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       operation;
    t_coord           left;
    t_coord           top;
    t_coord           right;
    t_coord           bottom;
    logic [3:0]       entry_index;

    modport source (output valid, operation, left, top, right, bottom, entry_index,
                    input ready);
    modport sink (input valid, operation, left, top, right, bottom, entry_index,
                  output ready);
endinterface

interface drm_rsp_if import drm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [4:0]       rect_count;
    logic             gave_up;
    t_coord           out_left;
    t_coord           out_top;
    t_coord           out_right;
    t_coord           out_bottom;

    modport source (output valid, rect_count, gave_up, out_left, out_top, out_right,
                    out_bottom, input ready);
    modport sink (input valid, rect_count, gave_up, out_left, out_top, out_right,
                  out_bottom, output ready);
endinterface

FILE: hw/rtl/dirty_rect_merge_list_top.sv
// Top level of the dirty rectangle merge list: config registers, sequencer, rectangle RAM.
// Depends on drm_pkg, drm_if, drm_ram, drm_ctrl.
//
// Usage:
//   i_req carries one transaction per command: add a rectangle, read an entry, or clear.
//   o_rsp returns exactly one transaction per command: count, give-up flag and, for a
//   read, the rectangle (zero for add and clear, the full-screen rectangle after give-up).
//   i_cfg_we/i_cfg_idx/i_cfg_data write the full-screen rectangle registers; write them
//   only while no command is in flight.
// Sequencing:
//   One command at a time. An add scans the stored entries in order; on a hit it grows that
//   entry, runs a backward absorb pass from the tail down to the hit, then a compaction pass
//   that closes the gaps of absorbed entries; with no hit it appends or gives up. Each entry
//   visit is a read state and an evaluate state because the rectangle RAM read is registered.
// Reset (synchronous, active low) empties the list, clears give-up and loads the
//   full-screen rectangle 0,0,640,400. RAM contents are not cleared.
// Stall: a finished response waits in the output register; the next command is taken
//   meanwhile and its response is held back until the register frees up.
module dirty_rect_merge_list_top import drm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drm_req_if.sink    i_req,
    drm_rsp_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  t_coord     i_cfg_data
);
    t_rect    r_max;
    t_mem_req mem;
    t_rect    rdata;
    t_stat    stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max.l <= t_coord'(0);
            r_max.t <= t_coord'(0);
            r_max.r <= t_coord'(640);
            r_max.b <= t_coord'(400);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_LEFT:   r_max.l <= i_cfg_data;
                REG_MAX_TOP:    r_max.t <= i_cfg_data;
                REG_MAX_RIGHT:  r_max.r <= i_cfg_data;
                REG_MAX_BOTTOM: r_max.b <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    drm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_max_rect (r_max),
        .o_mem      (mem),
        .i_rdata    (rdata),
        .o_stat     (stat)
    );

    drm_ram #(
        .DEPTH (MAX_RECTS),
        .WIDTH (RECT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

`ifndef SYNTHESIS
    // the list never holds more than its capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.cnt <= CNT_W'(MAX_RECTS))
        else $error("entry count above capacity");

    // give-up always reports a count of one
    a_gave_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.gave_up |-> o_rsp.rect_count == 5'd1)
        else $error("give-up with count other than one");

    // a taken command keeps the block busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> stat.busy)
        else $error("sequencer idle right after a command");

    // never read and write the same entry in one cycle
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem.we && mem.re |-> mem.waddr != mem.raddr)
        else $error("RAM read and write collide");
`endif
endmodule

FILE: hw/rtl/drm_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module drm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/drm_ctrl.sv
// Sequencer of the dirty rectangle merge list: scan, backward absorb, compaction, output reg.
// Depends on drm_pkg, drm_if; drives the rectangle RAM.
module drm_ctrl import drm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    drm_req_if.sink   i_req,
    drm_rsp_if.source o_rsp,
    input  t_rect     i_max_rect,
    output t_mem_req  o_mem,
    input  t_rect     i_rdata,
    output t_stat     o_stat
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN_RD = 4'd1;
    localparam logic [3:0] S_SCAN_EV = 4'd2;
    localparam logic [3:0] S_BACK_RD = 4'd3;
    localparam logic [3:0] S_BACK_EV = 4'd4;
    localparam logic [3:0] S_CMP_RD  = 4'd5;
    localparam logic [3:0] S_CMP_EV  = 4'd6;
    localparam logic [3:0] S_RD_EV   = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]           r_state;
    t_rect                r_nb;
    t_rect                r_grown;
    t_rect                r_res;
    logic [IDX_W-1:0]     r_a;
    logic [CNT_W-1:0]     r_j;
    logic [CNT_W-1:0]     r_w;
    logic [MAX_RECTS-1:0] r_rm;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_gave;
    logic                 r_ovalid;
    logic [4:0]           r_ocnt;
    logic                 r_ogave;
    t_rect                r_ores;

    t_rect req_rect;
    logic  accept;
    logic  out_free;

    assign req_rect = '{l: i_req.left, t: i_req.top, r: i_req.right, b: i_req.bottom};
    assign i_req.ready = (r_state == S_IDLE);
    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;

    // memory access per state
    always_comb begin
        o_mem = '0;
        unique case (r_state)
            S_IDLE: begin
                o_mem.re    = accept && (i_req.operation == OP_READ);
                o_mem.raddr = i_req.entry_index[IDX_W-1:0];
            end
            S_SCAN_RD: begin
                if (r_j == r_cnt) begin
                    o_mem.we    = (r_cnt < CNT_W'(MAX_RECTS));
                    o_mem.waddr = r_cnt[IDX_W-1:0];
                    o_mem.wdata = r_nb;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_j[IDX_W-1:0];
                end
            end
            S_BACK_RD: begin
                if (r_j == CNT_W'(r_a)) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_a;
                    o_mem.wdata = r_grown;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_j[IDX_W-1:0];
                end
            end
            S_CMP_RD: begin
                o_mem.re    = (r_j != r_cnt) && !r_rm[r_j[IDX_W-1:0]];
                o_mem.raddr = r_j[IDX_W-1:0];
            end
            S_CMP_EV: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_w[IDX_W-1:0];
                o_mem.wdata = i_rdata;
            end
            S_SCAN_EV, S_BACK_EV, S_RD_EV, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_gave   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (r_ovalid && o_rsp.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_nb  <= req_rect;
                        r_res <= '0;
                        if ((i_req.operation == OP_ADD) && !r_gave &&
                            req_rect.r != req_rect.l && req_rect.b != req_rect.t) begin
                            r_j     <= '0;
                            r_state <= S_SCAN_RD;
                        end else if (i_req.operation == OP_READ) begin
                            r_j     <= CNT_W'(i_req.entry_index);
                            r_state <= S_RD_EV;
                        end else begin
                            if (i_req.operation == OP_CLEAR) begin
                                r_cnt  <= '0;
                                r_gave <= 1'b0;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN_RD: begin
                    if (r_j == r_cnt) begin
                        // no overlap: append or give up
                        if (r_cnt < CNT_W'(MAX_RECTS)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_gave <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SCAN_EV;
                    end
                end
                S_SCAN_EV: begin
                    if (rect_overlap(i_rdata, r_nb)) begin
                        r_grown <= rect_union(i_rdata, r_nb);
                        r_a     <= r_j[IDX_W-1:0];
                        r_j     <= r_cnt - 1'b1;
                        r_rm    <= '0;
                        r_state <= S_BACK_RD;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_BACK_RD: begin
                    if (r_j == CNT_W'(r_a)) begin
                        r_j     <= CNT_W'(r_a) + 1'b1;
                        r_w     <= CNT_W'(r_a) + 1'b1;
                        r_state <= S_CMP_RD;
                    end else begin
                        r_state <= S_BACK_EV;
                    end
                end
                S_BACK_EV: begin
                    if (rect_overlap(r_grown, i_rdata)) begin
                        r_grown <= rect_union(r_grown, i_rdata);
                        r_rm[r_j[IDX_W-1:0]] <= 1'b1;
                    end
                    r_j     <= r_j - 1'b1;
                    r_state <= S_BACK_RD;
                end
                S_CMP_RD: begin
                    if (r_j == r_cnt) begin
                        r_cnt   <= r_w;
                        r_state <= S_DONE;
                    end else if (r_rm[r_j[IDX_W-1:0]]) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_state <= S_CMP_EV;
                    end
                end
                S_CMP_EV: begin
                    r_w     <= r_w + 1'b1;
                    r_j     <= r_j + 1'b1;
                    r_state <= S_CMP_RD;
                end
                S_RD_EV: begin
                    if (r_gave) begin
                        r_res <= i_max_rect;
                    end else if (r_j < r_cnt) begin
                        r_res <= i_rdata;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ocnt   <= r_gave ? 5'd1 : 5'(r_cnt);
                        r_ogave  <= r_gave;
                        r_ores   <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.rect_count = r_ocnt;
    assign o_rsp.gave_up    = r_ogave;
    assign o_rsp.out_left   = r_ores.l;
    assign o_rsp.out_top    = r_ores.t;
    assign o_rsp.out_right  = r_ores.r;
    assign o_rsp.out_bottom = r_ores.b;

    assign o_stat = '{cnt: r_cnt, gave: r_gave, busy: (r_state != S_IDLE)};
endmodule

FILE: sim/drm_tb_if.sv
// Testbench-side transaction types for the channels; the bench reuses the block's own interfaces.
// Depends on drm_pkg from the RTL; this file only holds a small helper package.
package drm_tb_pkg;
    import drm_pkg::*;

    // one request transaction as the testbench composes it
    typedef struct {
        logic [1:0] op;
        t_rect      rect;
        logic [3:0] idx;
    } t_cmd;

    // one response transaction
    typedef struct {
        logic [4:0] cnt;
        logic       gave;
        t_rect      rect;
    } t_resp;
endpackage

FILE: sim/testbench.sv
// Self-checking testbench for dirty_rect_merge_list_top: directed and random commands,
// a behavioral list-merge predictor and an in-order response checker.
// Depends on drm_pkg, drm_if (RTL) and drm_tb_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import drm_pkg::*;
    import drm_tb_pkg::*;

    // operation code with no function
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = REG_MAX_LEFT;
    t_coord     i_cfg_data = '0;

    drm_req_if req_if ();
    drm_rsp_if rsp_if ();

    dirty_rect_merge_list_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- predictor state ----------------
    t_rect      pred_list [MAX_RECTS];
    int         pred_count;
    bit         pred_gave;
    t_rect      screen_rect;
    t_resp      pending_resp [$];

    int         fail_count;
    int         resp_seen;
    int         gave_up_seen;
    int         merges_seen;
    bit         sender_gaps;
    bit         sink_gaps;
    bit         long_hold;
    longint     cycle_count;

    function automatic bit boxes_touch(t_rect p, t_rect q);
        t_coord lo_x, hi_x, lo_y, hi_y;
        lo_x = (p.l > q.l) ? p.l : q.l;
        hi_x = (p.r < q.r) ? p.r : q.r;
        lo_y = (p.t > q.t) ? p.t : q.t;
        hi_y = (p.b < q.b) ? p.b : q.b;
        return (lo_x < hi_x) && (lo_y < hi_y);
    endfunction

    function automatic t_rect bounding_box(t_rect p, t_rect q);
        t_rect u;
        u.l = (p.l < q.l) ? p.l : q.l;
        u.t = (p.t < q.t) ? p.t : q.t;
        u.r = (p.r > q.r) ? p.r : q.r;
        u.b = (p.b > q.b) ? p.b : q.b;
        return u;
    endfunction

    // Insert into the damage list: grow the first hit, then absorb later hits
    // walking back from the tail, keeping order.
    function automatic void merge_damage(t_rect nb);
        int a;
        int b;
        if (pred_gave) return;
        if (nb.r == nb.l || nb.b == nb.t) return;
        for (a = 0; a < pred_count; a++) begin
            if (boxes_touch(pred_list[a], nb)) begin
                pred_list[a] = bounding_box(pred_list[a], nb);
                for (b = pred_count - 1; b > a; b--) begin
                    if (boxes_touch(pred_list[a], pred_list[b])) begin
                        pred_list[a] = bounding_box(pred_list[a], pred_list[b]);
                        for (int k = b; k + 1 < pred_count; k++)
                            pred_list[k] = pred_list[k + 1];
                        pred_count--;
                        merges_seen++;
                    end
                end
                return;
            end
        end
        if (pred_count >= MAX_RECTS) begin
            pred_gave = 1'b1;
            gave_up_seen++;
            return;
        end
        pred_list[pred_count] = nb;
        pred_count++;
    endfunction

    function automatic t_resp predict_response(t_cmd c);
        t_resp r;
        r.rect = '0;
        case (c.op)
            OP_ADD: merge_damage(c.rect);
            OP_READ: begin
                if (pred_gave) r.rect = screen_rect;
                else if (c.idx < pred_count) r.rect = pred_list[c.idx];
            end
            OP_CLEAR: begin
                pred_count = 0;
                pred_gave = 1'b0;
            end
            default: ;
        endcase
        r.cnt = pred_gave ? 5'd1 : 5'(pred_count);
        r.gave = pred_gave;
        return r;
    endfunction

    // ---------------- request driver ----------------
    initial begin
        req_if.valid = 1'b0;
        req_if.operation = OP_CLEAR;
        req_if.left = '0;
        req_if.top = '0;
        req_if.right = '0;
        req_if.bottom = '0;
        req_if.entry_index = '0;
    end

    // valid stays high after acceptance; next call replaces or drops it, drain() drops it
    task automatic send_cmd(t_cmd c);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.operation <= c.op;
        req_if.left <= c.rect.l;
        req_if.top <= c.rect.t;
        req_if.right <= c.rect.r;
        req_if.bottom <= c.rect.b;
        req_if.entry_index <= c.idx;
        // predict at issue; the block serves commands in order
        pending_resp.insert(pending_resp.size(), predict_response(c));
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // ---------------- response sink: random stalls plus one long hold-off ----------------
    int hold_cycles;
    initial begin
        rsp_if.ready = 1'b0;
        hold_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp_if.ready <= (hold_cycles == 0);
            end else if (long_hold) begin
                long_hold = 1'b0;
                hold_cycles = 300;
                rsp_if.ready <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                hold_cycles = $urandom_range(1, 17);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ---------------- response checker ----------------
    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            resp_seen++;
            if (pending_resp.size() == 0) begin
                $display("%0t: unexpected transaction cnt=%0d", $realtime, rsp_if.rect_count);
                fail_count++;
            end else begin
                want = pending_resp.pop_front();
                if (rsp_if.rect_count !== want.cnt) begin
                    $display("%0t: rect_count expected %0d actual %0d",
                             $realtime, want.cnt, rsp_if.rect_count);
                    fail_count++;
                end
                if (rsp_if.gave_up !== want.gave) begin
                    $display("%0t: gave_up expected %0b actual %0b",
                             $realtime, want.gave, rsp_if.gave_up);
                    fail_count++;
                end
                if ({rsp_if.out_left, rsp_if.out_top, rsp_if.out_right, rsp_if.out_bottom}
                        !== want.rect) begin
                    $display("%0t: rect expected %0d,%0d,%0d,%0d actual %0d,%0d,%0d,%0d",
                             $realtime, want.rect.l, want.rect.t, want.rect.r, want.rect.b,
                             rsp_if.out_left, rsp_if.out_top, rsp_if.out_right,
                             rsp_if.out_bottom);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 1_000_000) begin
            $display("%0t: timeout, %0d transactions outstanding", $realtime,
                     pending_resp.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- helpers ----------------
    function automatic t_cmd make_cmd(logic [1:0] op, int l, int t, int r, int b, int idx);
        t_cmd c;
        c.op = op;
        c.rect.l = t_coord'(l);
        c.rect.t = t_coord'(t);
        c.rect.r = t_coord'(r);
        c.rect.b = t_coord'(b);
        c.idx = 4'(idx);
        return c;
    endfunction

    // wait for all responses, then some idle cycles for trailing work
    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // only while idle
    task automatic write_screen(int l, int t, int r, int b);
        int v [4];
        v = '{l, t, r, b};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 2'(i);
            i_cfg_data <= t_coord'(v[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        screen_rect.l = t_coord'(l);
        screen_rect.t = t_coord'(t);
        screen_rect.r = t_coord'(r);
        screen_rect.b = t_coord'(b);
    endtask

    task automatic read_all();
        for (int i = 0; i < MAX_RECTS; i++)
            send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, i));
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0));             // empty list read
        send_cmd(make_cmd(OP_ADD, 10, 10, 10, 50, 0));          // zero width
        send_cmd(make_cmd(OP_ADD, 10, 10, 50, 10, 0));          // zero height
        send_cmd(make_cmd(OP_ADD, -32768, -32768, 32767, 32767, 0));
        send_cmd(make_cmd(OP_ADD, 100, 100, 200, 200, 0));      // absorbed into first
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 15));            // out of range
        send_cmd(make_cmd(OP_UNUSED, 0, 0, 0, 0, 0));           // unused code
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_ADD, 50, 50, 10, 10, 0));          // inverted: appended
        send_cmd(make_cmd(OP_ADD, 0, 0, 10, 10, 0));
        send_cmd(make_cmd(OP_ADD, 20, 0, 30, 10, 0));
        send_cmd(make_cmd(OP_ADD, 10, 0, 20, 10, 0));           // edge touch only
        send_cmd(make_cmd(OP_ADD, 5, 5, 25, 8, 0));            // bridges, backward absorb
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 1));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 2));
        // fill to overflow with disjoint boxes
        for (int i = 0; i < MAX_RECTS + 1; i++)
            send_cmd(make_cmd(OP_ADD, 1000 + 20 * i, 1000, 1010 + 20 * i, 1010, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 9));             // screen after give-up
        send_cmd(make_cmd(OP_ADD, 0, 0, 5, 5, 0));              // ignored while given up
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
        drain();
    endtask

    // random box in a small window so overlaps are common; edges occasionally extreme
    function automatic t_cmd rand_cmd(int span);
        t_cmd c;
        int sel;
        int x, y;
        sel = $urandom_range(0, 99);
        c.idx = 4'($urandom_range(0, 15));
        if (sel < 70) begin
            c.op = OP_ADD;
            x = $urandom_range(0, span);
            y = $urandom_range(0, span);
            c.rect.l = t_coord'(x);
            c.rect.t = t_coord'(y);
            c.rect.r = t_coord'(x + $urandom_range(0, 40));
            c.rect.b = t_coord'(y + $urandom_range(0, 40));
            if ($urandom_range(0, 19) == 0) c.rect = t_rect'({$urandom, $urandom});
        end else if (sel < 95) begin
            c.op = OP_READ;
            c.rect = t_rect'({$urandom, $urandom});
        end else begin
            c.op = (sel < 98) ? OP_CLEAR : OP_UNUSED;
            c.rect = t_rect'({$urandom, $urandom});
        end
        return c;
    endfunction

    task automatic test_random(int n, int span);
        for (int i = 0; i < n; i++) send_cmd(rand_cmd(span));
        drain();
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        long_hold = 1'b1;
        for (int i = 0; i < 30; i++) send_cmd(rand_cmd(300));
        drain();
    endtask

    initial begin
        pred_count = 0;
        pred_gave = 1'b0;
        screen_rect = '{l: 0, t: 0, r: 640, b: 400};
        fail_count = 0;
        resp_seen = 0;
        gave_up_seen = 0;
        merges_seen = 0;
        cycle_count = 0;
        long_hold = 1'b0;
        sender_gaps = 1'b1;
        sink_gaps = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_screen(-32768, -32768, 32767, 32767);
        test_random(400, 200);
        test_backpressure();
        write_screen(32767, 32767, -32768, -32768);
        test_random(400, 2000);
        write_screen(-5, 7, 1920, 1080);
        test_random(350, 600);
        sender_gaps = 1'b0;
        sink_gaps = 1'b0;
        test_random(350, 400);
        read_all();
        drain();

        $display("Covered %0d responses, %0d give-up events, %0d backward absorbs,",
                 resp_seen, gave_up_seen, merges_seen);
        $display("four full-screen settings, random stalls and one long receiver hold-off.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
